### rtl/gear_shift_selector_defines.svh
// Assertion macros shared by the gear shift selector checker.
`ifndef GEAR_SHIFT_SELECTOR_DEFINES_SVH
`define GEAR_SHIFT_SELECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gear shift selector check failed");

// The consequent must hold in the cycle after the antecedent.
`define GSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gear shift selector check failed");

`endif

### rtl/gss_pkg.sv
// Shared types, codes and constants of the gear shift selector.
`timescale 1ns / 1ps

package gss_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned ThrW    = 10;
  localparam int unsigned BndW    = 10;
  localparam int unsigned HystW   = 8;
  localparam int unsigned LeverW  = 2;
  localparam int unsigned GearW   = 3;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 10;

  localparam logic [ThrW-1:0]  ThrottleMax = 10'd1000;
  localparam logic [GearW-1:0] GearFirst   = 3'd1;
  localparam logic [GearW-1:0] GearTop     = 3'd4;

  localparam logic [BndW-1:0]  RstBnd12 = 10'd200;
  localparam logic [BndW-1:0]  RstBnd23 = 10'd500;
  localparam logic [BndW-1:0]  RstBnd34 = 10'd800;
  localparam logic [HystW-1:0] RstHyst  = 8'd10;

  typedef enum logic [ModeW-1:0] {
    EvCycleLever = 3'd0,
    EvToggleMode = 3'd1,
    EvManualUp   = 3'd2,
    EvManualDown = 3'd3,
    EvAutoEval   = 3'd4
  } gss_event_e;

  typedef enum logic [LeverW-1:0] {
    LeverPark    = 2'd0,
    LeverReverse = 2'd1,
    LeverNeutral = 2'd2,
    LeverDrive   = 2'd3
  } gss_lever_e;

  typedef enum logic {
    DriveAuto   = 1'b0,
    DriveManual = 1'b1
  } gss_drive_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBnd12 = 4'd0,
    CfgBnd23 = 4'd1,
    CfgBnd34 = 4'd2,
    CfgHyst  = 4'd3
  } gss_cfg_idx_e;

  typedef struct packed {
    logic [BndW-1:0]  bnd12;
    logic [BndW-1:0]  bnd23;
    logic [BndW-1:0]  bnd34;
    logic [HystW-1:0] hyst;
  } gss_cfg_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ThrW-1:0]  throttle;
  } gss_item_t;

endpackage

### rtl/gss_cfg_regs.sv
// Configuration registers: shift boundaries and automatic hysteresis.
`timescale 1ns / 1ps

module gss_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gss_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gss_pkg::CfgDatW-1:0] cfg_data_i,
  output gss_pkg::gss_cfg_t           cfg_o
);
  import gss_pkg::*;

  gss_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBnd12: cfg_d.bnd12 = cfg_data_i[BndW-1:0];
        CfgBnd23: cfg_d.bnd23 = cfg_data_i[BndW-1:0];
        CfgBnd34: cfg_d.bnd34 = cfg_data_i[BndW-1:0];
        CfgHyst:  cfg_d.hyst  = cfg_data_i[HystW-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bnd12 <= RstBnd12;
      cfg_q.bnd23 <= RstBnd23;
      cfg_q.bnd34 <= RstBnd34;
      cfg_q.hyst  <= RstHyst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/gss_in_stage.sv
// Input register stage that holds one accepted event beat.
`timescale 1ns / 1ps

module gss_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gss_pkg::gss_item_t item_i,
  output logic               item_valid_o,
  input  logic               item_ready_i,
  output gss_pkg::gss_item_t item_o
);
  import gss_pkg::*;

  logic      valid_q, valid_d;
  gss_item_t item_q;

  assign in_ready_o = !valid_q || item_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### rtl/gss_shift_core.sv
// Selector state, shift decision logic and the result register.
`timescale 1ns / 1ps

module gss_shift_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       item_valid_i,
  output logic                       item_ready_o,
  input  gss_pkg::gss_item_t         item_i,
  input  gss_pkg::gss_cfg_t          cfg_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [gss_pkg::LeverW-1:0] lever_o,
  output logic                       drive_mode_o,
  output logic [gss_pkg::GearW-1:0]  gear_o
);
  import gss_pkg::*;

  logic              fire;
  logic              out_valid_q, out_valid_d;
  logic [LeverW-1:0] lever_q, lever_d, lever_inc;
  logic              drive_q, drive_d;
  logic [GearW-1:0]  gear_q, gear_d;

  logic [ThrW-1:0]   thr_sat;
  logic              parked, gear_ok;
  logic [BndW-1:0]   up_bnd, lo_bnd;
  logic [BndW:0]     up_lim, thr_plus_h;
  logic              auto_up, auto_dn;

  // The result register is the state itself: it only moves when the result slot is free.
  assign item_ready_o = !out_valid_q || out_ready_i;
  assign fire         = item_valid_i && item_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    thr_sat = (item_i.throttle > ThrottleMax) ? ThrottleMax : item_i.throttle;
    parked  = (lever_q == LeverPark);
    gear_ok = (gear_q >= GearFirst) && (gear_q <= GearTop);

    case (gear_q)
      3'd1:    up_bnd = cfg_i.bnd12;
      3'd2:    up_bnd = cfg_i.bnd23;
      default: up_bnd = cfg_i.bnd34;
    endcase
    case (gear_q)
      3'd2:    lo_bnd = cfg_i.bnd12;
      3'd3:    lo_bnd = cfg_i.bnd23;
      default: lo_bnd = cfg_i.bnd34;
    endcase

    // Lower bound minus hysteresis is compared as throttle plus hysteresis, so a
    // negative bound never causes a downshift.
    up_lim     = {1'b0, up_bnd} + {{(BndW + 1 - HystW){1'b0}}, cfg_i.hyst};
    thr_plus_h = {1'b0, thr_sat} + {{(BndW + 1 - HystW){1'b0}}, cfg_i.hyst};
    auto_up    = (gear_q < GearTop) && ({1'b0, thr_sat} > up_lim);
    auto_dn    = (gear_q > GearFirst) && (thr_plus_h < {1'b0, lo_bnd});
    lever_inc  = lever_q + 2'd1;
  end

  always_comb begin
    lever_d = lever_q;
    drive_d = drive_q;
    gear_d  = gear_q;
    if (fire) begin
      case (gss_event_e'(item_i.mode))
        EvCycleLever: begin
          lever_d = lever_inc;
          if (lever_inc == LeverNeutral || lever_inc == LeverDrive) begin
            gear_d = GearFirst;
          end
        end
        EvToggleMode: begin
          drive_d = !drive_q;
        end
        EvManualUp: begin
          if (drive_q == DriveManual && !parked && gear_q >= GearFirst &&
              gear_q < GearTop && thr_sat > up_bnd) begin
            gear_d = gear_q + 3'd1;
          end
        end
        EvManualDown: begin
          if (drive_q == DriveManual && !parked && gear_q > GearFirst &&
              gear_q <= GearTop && thr_sat < lo_bnd) begin
            gear_d = gear_q - 3'd1;
          end
        end
        EvAutoEval: begin
          if (drive_q == DriveAuto && !parked) begin
            if (!gear_ok) begin
              gear_d = GearFirst;
            end else if (auto_up) begin
              gear_d = gear_q + 3'd1;
            end else if (auto_dn) begin
              gear_d = gear_q - 3'd1;
            end
          end
        end
        default: begin
          gear_d = gear_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      lever_q     <= LeverPark;
      drive_q     <= DriveAuto;
      gear_q      <= GearFirst;
    end else begin
      out_valid_q <= out_valid_d;
      lever_q     <= lever_d;
      drive_q     <= drive_d;
      gear_q      <= gear_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lever_o      = lever_q;
  assign drive_mode_o = drive_q;
  assign gear_o       = gear_q;

endmodule

### rtl/gear_shift_selector.sv
// Top level of the gear shift selector.
// An event beat is registered in the input stage and then in the state/result register.
// Throughput: one event per cycle unless the output is stalled; the input register
// and the state/result register form a two-stage pipeline with one decision step
// between them. Reset: lever in park, automatic mode, first gear, boundaries
// 200/500/800, hysteresis 10; the block is ready right after reset is released.
`timescale 1ns / 1ps

module gear_shift_selector (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gss_pkg::ModeW-1:0]   mode_i,
  input  logic [gss_pkg::ThrW-1:0]    throttle_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gss_pkg::LeverW-1:0]  lever_position_o,
  output logic                        drive_mode_now_o,
  output logic [gss_pkg::GearW-1:0]   gear_now_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gss_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gss_pkg::CfgDatW-1:0] cfg_data_i
);
  import gss_pkg::*;

  gss_item_t in_item, stage_item;
  logic      stage_valid, stage_ready;
  gss_cfg_t  cfg;

  assign in_item.mode     = mode_i;
  assign in_item.throttle = throttle_i;

  gss_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gss_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .item_valid_o (stage_valid),
    .item_ready_i (stage_ready),
    .item_o       (stage_item)
  );

  gss_shift_core u_shift_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (stage_valid),
    .item_ready_o (stage_ready),
    .item_i       (stage_item),
    .cfg_i        (cfg),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .lever_o      (lever_position_o),
    .drive_mode_o (drive_mode_now_o),
    .gear_o       (gear_now_o)
  );

endmodule

### rtl/gss_checker.sv
// Port-level checker for the gear shift selector and its bind statement.
`timescale 1ns / 1ps
`include "gear_shift_selector_defines.svh"

module gss_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [gss_pkg::LeverW-1:0]  lever_position_o,
  input logic                        drive_mode_now_o,
  input logic [gss_pkg::GearW-1:0]   gear_now_o
);
  import gss_pkg::*;

  logic                     gear_in_range;
  logic                     out_stalled;
  logic [LeverW+GearW:0]    result_bits;

  assign gear_in_range = (gear_now_o >= GearFirst) && (gear_now_o <= GearTop);
  assign out_stalled   = out_valid_o && !out_ready_i;
  assign result_bits   = {lever_position_o, drive_mode_now_o, gear_now_o};

  // A reported gear is always one of the four forward gears.
  `GSS_ASSERT_SAME(a_gear_range, clk_i, rst_ni, out_valid_o, gear_in_range)

  // The input side never stalls while the output side is taking beats.
  `GSS_ASSERT_SAME(a_no_bubble_stall, clk_i, rst_ni, out_ready_i, in_ready_o)

  // A stalled result beat keeps its value.
  `GSS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stalled, out_valid_o && $stable(result_bits))

endmodule

bind gear_shift_selector gss_checker u_gss_checker (.*);

### test/tb_gear_shift_selector.sv
// Self-checking testbench of the gear shift selector with a predictor and random traffic.
`timescale 1ns / 1ps

module tb_gear_shift_selector;
  import gss_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldOffCycles = 120;

  typedef struct packed {
    logic [LeverW-1:0] lever;
    logic              drive;
    logic [GearW-1:0]  gear;
  } selector_status_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready_o;
  logic [ModeW-1:0]    mode;
  logic [ThrW-1:0]     throttle;
  logic                out_valid_o;
  logic                out_ready;
  logic [LeverW-1:0]   lever_position_o;
  logic                drive_mode_now_o;
  logic [GearW-1:0]    gear_now_o;
  logic                cfg_valid;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDatW-1:0]  cfg_data;

  gss_lever_e          lever_q;
  gss_drive_e          drive_q;
  logic [GearW-1:0]    gear_q;
  gss_cfg_t            limits_q;
  selector_status_t    status_expected[$];

  bit                  gaps_on;
  int                  hold_off;
  int                  events_sent;
  int                  results_seen;
  int                  register_writes;
  int                  input_stalls;
  int                  mismatches;
  int                  cycle_count;

  gear_shift_selector u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode),
    .throttle_i       (throttle),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .lever_position_o (lever_position_o),
    .drive_mode_now_o (drive_mode_now_o),
    .gear_now_o       (gear_now_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int boundary_above(input logic [GearW-1:0] g);
    case (g)
      3'd1: return int'(limits_q.bnd12);
      3'd2: return int'(limits_q.bnd23);
      default: return int'(limits_q.bnd34);
    endcase
  endfunction

  function automatic selector_status_t advance_selector(input logic [ModeW-1:0] ev,
                                                        input logic [ThrW-1:0] thr);
    int t;
    int h;
    logic parked;
    selector_status_t s;
    t = (thr > ThrottleMax) ? int'(ThrottleMax) : int'(thr);
    h = int'(limits_q.hyst);
    parked = (lever_q == LeverPark);
    case (ev)
      EvCycleLever: begin
        lever_q = gss_lever_e'(LeverW'(lever_q + 2'd1));
        if (lever_q == LeverNeutral || lever_q == LeverDrive) gear_q = GearFirst;
      end
      EvToggleMode: begin
        drive_q = (drive_q == DriveAuto) ? DriveManual : DriveAuto;
      end
      EvManualUp: begin
        if (drive_q == DriveManual && !parked && gear_q < GearTop &&
            t > boundary_above(gear_q))
          gear_q = gear_q + 3'd1;
      end
      EvManualDown: begin
        if (drive_q == DriveManual && !parked && gear_q > GearFirst &&
            t < boundary_above(gear_q - 3'd1))
          gear_q = gear_q - 3'd1;
      end
      EvAutoEval: begin
        if (drive_q == DriveAuto && !parked) begin
          if (gear_q < GearTop && t > boundary_above(gear_q) + h)
            gear_q = gear_q + 3'd1;
          else if (gear_q > GearFirst && t < boundary_above(gear_q - 3'd1) - h)
            gear_q = gear_q - 3'd1;
        end
      end
      default: ;
    endcase
    s.lever = lever_q;
    s.drive = drive_q;
    s.gear = gear_q;
    return s;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        register_writes++;
        case (cfg_index)
          CfgBnd12: limits_q.bnd12 = cfg_data;
          CfgBnd23: limits_q.bnd23 = cfg_data;
          CfgBnd34: limits_q.bnd34 = cfg_data;
          CfgHyst:  limits_q.hyst = cfg_data[HystW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready_o) begin
        status_expected.push_back(advance_selector(mode, throttle));
        events_sent++;
      end else if (in_valid) begin
        input_stalls++;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    selector_status_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      results_seen++;
      if (status_expected.size() == 0) begin
        $display("%0t: result beat with no event pending: lever %0d mode %0d gear %0d",
                 $time, lever_position_o, drive_mode_now_o, gear_now_o);
        mismatches++;
      end else begin
        want = status_expected.pop_front();
        if (lever_position_o !== want.lever) begin
          $display("%0t: lever expected %0d actual %0d", $time, want.lever, lever_position_o);
          mismatches++;
        end
        if (drive_mode_now_o !== want.drive) begin
          $display("%0t: drive mode expected %0d actual %0d", $time, want.drive,
                   drive_mode_now_o);
          mismatches++;
        end
        if (gear_now_o !== want.gear) begin
          $display("%0t: gear expected %0d actual %0d", $time, want.gear, gear_now_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run exceeded %0d cycles, %0d results outstanding", $time, CycleLimit,
               status_expected.size());
      $display("gear_shift_selector test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_event(input logic [ModeW-1:0] ev, input logic [ThrW-1:0] thr);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    mode <= ev;
    throttle <= thr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_settled();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (status_expected.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDatW-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_limits(input logic [CfgDatW-1:0] b12, input logic [CfgDatW-1:0] b23,
                                input logic [CfgDatW-1:0] b34, input logic [CfgDatW-1:0] hy);
    wait_settled();
    write_register(CfgBnd12, b12);
    write_register(CfgBnd23, b23);
    write_register(CfgBnd34, b34);
    write_register(CfgHyst, hy);
  endtask

  task automatic send_random_events(input int count);
    int r;
    int v;
    logic [ModeW-1:0] ev;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) ev = EvCycleLever;
      else if (r < 14) ev = EvToggleMode;
      else if (r < 40) ev = EvManualUp;
      else if (r < 66) ev = EvManualDown;
      else if (r < 96) ev = EvAutoEval;
      else ev = ModeW'($urandom_range(EvAutoEval + 1, (1 << ModeW) - 1));
      r = $urandom_range(0, 9);
      if (r < 5) begin
        v = $urandom_range(0, ThrottleMax);
      end else if (r < 8) begin
        v = boundary_above(GearW'($urandom_range(1, 3)));
        case ($urandom_range(0, 2))
          0: v = v + int'(limits_q.hyst);
          1: v = v - int'(limits_q.hyst);
          default: ;
        endcase
        v = v + $urandom_range(0, 4) - 2;
        if (v < 0) v = 0;
        if (v > (1 << ThrW) - 1) v = (1 << ThrW) - 1;
      end else if (r < 9) begin
        v = $urandom_range(0, 1) ? int'(ThrottleMax) : 0;
      end else begin
        v = $urandom_range(ThrottleMax + 1, (1 << ThrW) - 1);
      end
      send_event(ev, ThrW'(v));
    end
  endtask

  task automatic test_directed_events();
    gaps_on = 1'b0;
    send_event(EvAutoEval, 10'd1000);
    send_event(EvManualUp, 10'd1000);
    for (int c = EvAutoEval + 1; c < (1 << ModeW); c++) send_event(ModeW'(c), 10'h3FF);
    send_event(EvCycleLever, 10'd0);
    send_event(EvAutoEval, 10'd1000);
    send_event(EvAutoEval, 10'h3FF);
    send_event(EvAutoEval, 10'd0);
    send_event(EvCycleLever, 10'd0);
    send_event(EvCycleLever, 10'd0);
    send_event(EvToggleMode, 10'd0);
    send_event(EvManualUp, 10'd201);
    send_event(EvManualUp, 10'd500);
    send_event(EvManualUp, 10'd1001);
    send_event(EvManualUp, 10'h3FF);
    send_event(EvManualUp, 10'h3FF);
    send_event(EvManualDown, 10'd799);
    send_event(EvManualDown, 10'd500);
    send_event(EvManualDown, 10'd0);
    send_event(EvManualDown, 10'd0);
    send_event(EvAutoEval, 10'd1000);
    send_event(EvToggleMode, 10'd0);
    send_event(EvAutoEval, 10'd211);
    send_event(EvAutoEval, 10'd189);
    send_event(EvCycleLever, 10'd0);
    wait_settled();
  endtask

  task automatic test_register_extremes();
    gaps_on = 1'b1;
    program_limits(10'd0, 10'd0, 10'd0, 10'd0);
    send_event(EvCycleLever, 10'd0);
    send_random_events(20);
    program_limits(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
    send_random_events(20);
    program_limits(ThrottleMax, ThrottleMax, ThrottleMax, 10'd200);
    send_random_events(20);
    // Every lower boundary minus the hysteresis is negative, so no auto downshift occurs.
    program_limits(10'd5, 10'd100, 10'd190, 10'd200);
    send_random_events(25);
    wait_settled();
    for (int idx = CfgHyst + 1; idx < (1 << CfgIdxW); idx++)
      write_register(CfgIdxW'(idx), CfgDatW'($urandom));
    send_random_events(20);
    program_limits(RstBnd12, RstBnd23, RstBnd34, CfgDatW'(RstHyst));
    send_random_events(20);
    wait_settled();
  endtask

  task automatic test_random_traffic();
    int lo;
    for (int phase = 0; phase < 6; phase++) begin
      gaps_on = (phase % 3) != 2;
      lo = $urandom_range(0, 400);
      program_limits(CfgDatW'(lo), CfgDatW'($urandom_range(lo, 800)),
                     CfgDatW'($urandom_range(lo, ThrottleMax)),
                     CfgDatW'($urandom_range(0, 200)));
      send_random_events(35);
    end
    wait_settled();
  endtask

  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    send_event(EvCycleLever, 10'd0);
    hold_off = HoldOffCycles;
    send_random_events(40);
    gaps_on = 1'b1;
    send_random_events(20);
    wait_settled();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    mode = EvCycleLever;
    throttle = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgBnd12;
    cfg_data = '0;
    gaps_on = 1'b0;
    hold_off = 0;
    lever_q = LeverPark;
    drive_q = DriveAuto;
    gear_q = GearFirst;
    limits_q = '{bnd12: RstBnd12, bnd23: RstBnd23, bnd34: RstBnd34, hyst: RstHyst};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_events();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();

    $display("Covered %0d events and %0d results over %0d register writes.",
             events_sent, results_seen, register_writes);
    $display("The input was held back for %0d cycles; %0d mismatches were found.",
             input_stalls, mismatches);
    if (mismatches == 0 && status_expected.size() == 0) begin
      $display("gear_shift_selector test passed");
    end else begin
      $display("gear_shift_selector test failed");
    end
    $finish;
  end

endmodule
